// ===== design/mips_subset_core_step_unit_defines.svh =====
// ----------------------------------------------------------------------------
// mips_subset_core_step_unit_defines
// Assertion macros for the core files. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_CORE_STEP_UNIT_DEFINES_SVH
`define MIPS_SUBSET_CORE_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define MSC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Types, opcodes and defaults for the MIPS subset step core.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    localparam int MEM_WORDS_DEF = 1024;
    localparam int RF_DEPTH      = 32;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // major opcodes
    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J     = 6'd2;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_BNE   = 6'd5;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;

    // R-type function codes
    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_SLT = 6'h2A;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  load_addr;
        logic [31:0] load_word;
    } req_t;

    typedef struct packed {
        logic [31:0] pc_after;
        logic [31:0] instruction;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic        halted;
        logic        bad_instruction;
    } rsp_t;

    // execute outcome, handed from the execute unit to the sequencer
    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_we;
        logic [4:0]  dest;
        logic [31:0] val;
        logic        is_load;
        logic        mem_we;
        logic        dmem_ok;
        logic        halt;
        logic        bad;
    } exec_res_t;

endpackage

`default_nettype wire

// ===== design/mips_subset_core_step_unit.sv =====
// ----------------------------------------------------------------------------
// mips_subset_core_step_unit
// MIPS32 subset core, one instruction step or one program-word load per
// request transaction, one response transaction each.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload | carries
//  --------+----------------------+---------+-------------------------------
//  request | req_valid/req_stall  | req     | load word or step command
//  response| rsp_valid/rsp_stall  | rsp     | PC, instruction, write report
//
// Sequencing: fetch, register read and execute go through synchronous memories in
//   sequence, lw adding a data read; a load every cycle while the output is free.
// Reset: main memory is swept to zero word by word, requests stalled
//   meanwhile; register file entries clear through valid bits.
// Stalls: one request waits in a buffer ahead of the sequencer, one response in
//   the output register; a full output holds execute or lw data.
//
`default_nettype none

`include "mips_subset_core_step_unit_defines.svh"

module mips_subset_core_step_unit
    import msc_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_EXEC   = 4'b0100,
        S_MEM    = 4'b1000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic            buf_valid_reg;
    logic            buf_valid_next;
    req_t            buf_reg;
    req_t            buf_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_t            rsp_reg;
    rsp_t            rsp_next;
    logic [31:0]     pc_reg;
    logic [31:0]     pc_next;
    logic [31:0]     instr_reg;
    logic [31:0]     instr_next;
    logic            fetch_ok_reg;
    logic            fetch_ok_next;
    logic            lw_ok_reg;
    logic            lw_ok_next;
    logic            clr_busy_reg;
    logic            clr_busy_next;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   clr_addr_next;

    logic            accept;
    logic            out_free;
    logic            take;
    logic            take_load;
    logic            take_step;
    logic            load_ok;
    logic            fetch_ok;
    logic            go_mem;
    logic            finish_exec;
    logic            finish_mem;
    logic            finish_step;
    logic            sw_we;
    logic [31:0]     instr_fetched;
    logic [31:0]     lw_data;
    logic [31:0]     wb_val;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [31:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [31:0]     mem_rdata;

    logic [31:0]     rf_a;
    logic [31:0]     rf_b;
    logic            rf_we;

    exec_res_t       exec_res;
    logic [AW-1:0]   dmem_addr;

    // ---- main memory: program and data, one write and one read port ----
    msc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_main_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // ---- register file, read in DECODE, written when the step finishes ----
    msc_regfile u_regfile (
        .clk  (clk),
        .rst_n(rst_n),
        .re   (state_reg == S_DECODE),
        .rs   (instr_fetched[25:21]),
        .rt   (instr_fetched[20:16]),
        .a    (rf_a),
        .b    (rf_b),
        .we   (rf_we),
        .wa   (exec_res.dest),
        .wd   (wb_val)
    );

    // ---- execute: works on the held instruction, PC and operands ----
    msc_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
        .instr    (instr_reg),
        .pc       (pc_reg),
        .a        (rf_a),
        .b        (rf_b),
        .res      (exec_res),
        .dmem_addr(dmem_addr)
    );

    // ---- handshake and sequencing conditions ----
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign take      = (state_reg == S_IDLE) && buf_valid_reg && !clr_busy_reg
                       && ((buf_reg.req_type == REQ_STEP) || out_free);
    assign take_load = take && (buf_reg.req_type == REQ_LOAD);
    assign take_step = take && (buf_reg.req_type == REQ_STEP);
    // the buffer frees in the same cycle it is drained
    assign req_stall = clr_busy_reg || (buf_valid_reg && !take);
    assign accept    = req_valid && !req_stall;

    assign load_ok   = {22'd0, buf_reg.load_addr} < 32'(MEM_WORDS);
    assign fetch_ok  = {2'b00, pc_reg[31:2]} < 32'(MEM_WORDS);

    // fetch beyond memory reads as zero, which halts
    assign instr_fetched = fetch_ok_reg ? mem_rdata : '0;
    assign lw_data       = lw_ok_reg ? mem_rdata : '0;

    assign go_mem      = (state_reg == S_EXEC) && exec_res.is_load;
    assign finish_exec = (state_reg == S_EXEC) && !exec_res.is_load && out_free;
    assign finish_mem  = (state_reg == S_MEM) && out_free;
    assign finish_step = finish_exec || finish_mem;
    assign sw_we       = finish_exec && exec_res.mem_we;

    assign wb_val = (state_reg == S_MEM) ? (exec_res.reg_we ? lw_data : '0) : exec_res.val;
    assign rf_we  = finish_step && exec_res.reg_we;

    // ---- main memory port steering ----
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        priority if (clr_busy_reg)
        begin
            mem_we = 1'b1;
        end
        else if (take_load && load_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(buf_reg.load_addr);
            mem_wdata = buf_reg.load_word;
        end
        else if (sw_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = dmem_addr;
            mem_wdata = rf_b;
        end
        else
        begin
            mem_we = 1'b0;
        end
        mem_re    = take_step || (go_mem && exec_res.dmem_ok);
        mem_raddr = go_mem ? dmem_addr : pc_reg[AW+1:2];
    end

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_step)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (go_mem)
                begin
                    state_next = S_MEM;
                end
                else if (finish_exec)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MEM:
            begin
                if (finish_mem)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        buf_next       = buf_reg;
        if (accept)
        begin
            buf_valid_next = 1'b1;
            buf_next       = req;
        end
        else if (take)
        begin
            buf_valid_next = 1'b0;
        end

        pc_next = pc_reg;
        if (take_load)
        begin
            pc_next = '0;
        end
        else if (finish_step)
        begin
            pc_next = exec_res.next_pc;
        end

        instr_next    = (state_reg == S_DECODE) ? instr_fetched : instr_reg;
        fetch_ok_next = take_step ? fetch_ok : fetch_ok_reg;
        lw_ok_next    = go_mem ? exec_res.dmem_ok : lw_ok_reg;

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MEM_WORDS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        // response register
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (take_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
        end
        else if (finish_step)
        begin
            rsp_valid_next           = 1'b1;
            rsp_next.pc_after        = exec_res.next_pc;
            rsp_next.instruction     = instr_reg;
            rsp_next.reg_written     = exec_res.reg_we;
            rsp_next.reg_index       = exec_res.dest;
            rsp_next.reg_value       = wb_val;
            rsp_next.mem_written     = exec_res.mem_we;
            rsp_next.halted          = exec_res.halt;
            rsp_next.bad_instruction = exec_res.bad;
        end
    end

    // ---- registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            buf_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pc_reg        <= '0;
            fetch_ok_reg  <= 1'b0;
            lw_ok_reg     <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            pc_reg        <= pc_next;
            fetch_ok_reg  <= fetch_ok_next;
            lw_ok_reg     <= lw_ok_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        rsp_reg   <= rsp_next;
        instr_reg <= instr_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---- checks ----
    `MSC_ASSERT_IMP(a_mem_wr_single, 1'b1, $onehot0({clr_busy_reg, take_load, sw_we}),
        "main memory write from more than one source")
    `MSC_ASSERT_IMP(a_clear_idle, clr_busy_reg, (state_reg == S_IDLE) && !take,
        "sequencer active during memory clear")
    `MSC_ASSERT_IMP(a_halt_quiet, finish_step && exec_res.halt,
        !exec_res.reg_we && !exec_res.mem_we && (exec_res.next_pc == pc_reg),
        "halted step wrote state or moved PC")
    `MSC_ASSERT_NXT(a_lw_to_mem, go_mem, state_reg == S_MEM,
        "lw did not enter data read state")

endmodule

`default_nettype wire

// ===== design/msc_ram.sv =====
// ----------------------------------------------------------------------------
// msc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/msc_regfile.sv =====
// ----------------------------------------------------------------------------
// msc_regfile
// 32 x 32 register file: two RAM copies for the rs and rt ports, valid bits
// so that never-written entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_regfile
    import msc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        re,
    input  logic [$clog2(RF_DEPTH)-1:0] rs,
    input  logic [$clog2(RF_DEPTH)-1:0] rt,
    output logic [31:0]                 a,
    output logic [31:0]                 b,
    input  logic                        we,
    input  logic [$clog2(RF_DEPTH)-1:0] wa,
    input  logic [31:0]                 wd
);

    logic [RF_DEPTH-1:0] valid_reg;
    logic [RF_DEPTH-1:0] valid_next;
    logic                a_ok_reg;
    logic                a_ok_next;
    logic                b_ok_reg;
    logic                b_ok_next;
    logic [31:0]         a_raw;
    logic [31:0]         b_raw;

    msc_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_ram_a (
        .clk  (clk),
        .we   (we),
        .waddr(wa),
        .wdata(wd),
        .re   (re),
        .raddr(rs),
        .rdata(a_raw)
    );

    msc_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_ram_b (
        .clk  (clk),
        .we   (we),
        .waddr(wa),
        .wdata(wd),
        .re   (re),
        .raddr(rt),
        .rdata(b_raw)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[wa] = 1'b1;
        end
        a_ok_next = re ? valid_reg[rs] : a_ok_reg;
        b_ok_next = re ? valid_reg[rt] : b_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            a_ok_reg  <= 1'b0;
            b_ok_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            a_ok_reg  <= a_ok_next;
            b_ok_reg  <= b_ok_next;
        end
    end

    assign a = a_ok_reg ? a_raw : '0;
    assign b = b_ok_reg ? b_raw : '0;

endmodule

`default_nettype wire

// ===== design/msc_exec.sv =====
// ----------------------------------------------------------------------------
// msc_exec
// Decode and execute of one instruction: ALU, branch and jump targets,
// data address and its range check.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_exec
    import msc_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic [31:0]                  instr,
    input  logic [31:0]                  pc,
    input  logic [31:0]                  a,
    input  logic [31:0]                  b,
    output exec_res_t                    res,
    output logic [$clog2(MEM_WORDS)-1:0] dmem_addr
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] pc4;
    logic [31:0] br_target;
    logic [31:0] daddr;
    logic        dmem_ok;
    logic        wr;
    logic [4:0]  dest;
    logic [31:0] val;

    assign op        = instr[31:26];
    assign rt        = instr[20:16];
    assign rd        = instr[15:11];
    assign sh        = instr[10:6];
    assign fn        = instr[5:0];
    assign imm       = {{16{instr[15]}}, instr[15:0]};
    assign pc4       = pc + 32'd4;
    assign br_target = pc4 + {imm[29:0], 2'b00};
    assign daddr     = a + imm;
    assign dmem_ok   = {2'b00, daddr[31:2]} < 32'(MEM_WORDS);
    assign dmem_addr = daddr[AW+1:2];

    always_comb
    begin
        res         = '0;
        res.next_pc = pc4;
        wr          = 1'b0;
        dest        = '0;
        val         = '0;
        if (instr == '0)
        begin
            // halted: PC holds
            res.halt    = 1'b1;
            res.next_pc = pc;
        end
        else
        begin
            unique case (op)
                OP_RTYPE:
                begin
                    wr   = 1'b1;
                    dest = rd;
                    unique case (fn)
                        FN_ADD:  val = a + b;
                        FN_SUB:  val = a - b;
                        FN_AND:  val = a & b;
                        FN_OR:   val = a | b;
                        FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                        FN_SLL:  val = b << sh;
                        FN_SRL:  val = b >> sh;
                        default:
                        begin
                            wr      = 1'b0;
                            res.bad = 1'b1;
                        end
                    endcase
                end
                OP_ADDI:
                begin
                    wr   = 1'b1;
                    dest = rt;
                    val  = daddr;
                end
                OP_LW:
                begin
                    wr          = 1'b1;
                    dest        = rt;
                    res.is_load = 1'b1;
                end
                OP_SW:
                begin
                    res.mem_we = dmem_ok;
                end
                OP_BEQ:
                begin
                    if (a == b)
                    begin
                        res.next_pc = br_target;
                    end
                end
                OP_BNE:
                begin
                    if (a != b)
                    begin
                        res.next_pc = br_target;
                    end
                end
                OP_J:
                begin
                    res.next_pc = {pc4[31:28], instr[25:0], 2'b00};
                end
                default:
                begin
                    res.bad = 1'b1;
                end
            endcase
        end
        res.reg_we  = wr && (dest != '0);
        res.dest    = res.reg_we ? dest : '0;
        res.val     = res.reg_we ? val : '0;
        res.dmem_ok = dmem_ok;
    end

endmodule

`default_nettype wire

// ===== tb/msc_step_checker.sv =====
// ----------------------------------------------------------------------------
// msc_step_checker
// Watches both channels of the MIPS subset step core. It keeps its own copy of
// the registers, PC and memory, works out each expected response and compares
// every accepted response field by field.
// ----------------------------------------------------------------------------
module msc_step_checker
    import msc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] gpr [RF_DEPTH];
    logic [31:0] pc_q;
    logic [31:0] word_mem [MEM_WORDS_DEF];
    rsp_t        expected_rsp_q [$];
    rsp_t        want;
    int unsigned mismatches = 0;
    int unsigned waiting    = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    // word read at a byte address; out of range reads as zero
    function automatic logic [31:0] read_word(logic [31:0] byte_addr);
        if ({2'b00, byte_addr[31:2]} >= 32'(MEM_WORDS_DEF))
            return '0;
        return word_mem[byte_addr[11:2]];
    endfunction

    // applies one request to the shadow core and returns the response it causes
    function automatic rsp_t run_core_item(req_t item);
        rsp_t        r;
        logic [31:0] ins, a, b, imm, nxt, val, ea;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh, dest;
        logic        wr;
        r = '0;
        if (item.req_type == REQ_LOAD) begin
            word_mem[item.load_addr] = item.load_word;
            pc_q = '0;
        end
        else begin
            ins = read_word(pc_q);
            r.instruction = ins;
            if (ins == '0) begin
                r.halted = 1'b1;
            end
            else begin
                op   = ins[31:26];
                rs   = ins[25:21];
                rt   = ins[20:16];
                rd   = ins[15:11];
                sh   = ins[10:6];
                fn   = ins[5:0];
                imm  = {{16{ins[15]}}, ins[15:0]};
                a    = gpr[rs];
                b    = gpr[rt];
                nxt  = pc_q + 32'd4;
                dest = '0;
                val  = '0;
                wr   = 1'b0;
                case (op)
                    OP_RTYPE:
                    begin
                        wr   = 1'b1;
                        dest = rd;
                        case (fn)
                            FN_ADD: val = a + b;
                            FN_SUB: val = a - b;
                            FN_AND: val = a & b;
                            FN_OR:  val = a | b;
                            FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            FN_SLL: val = b << sh;
                            FN_SRL: val = b >> sh;
                            default:
                            begin
                                wr = 1'b0;
                                r.bad_instruction = 1'b1;
                            end
                        endcase
                    end
                    OP_ADDI:
                    begin
                        wr   = 1'b1;
                        dest = rt;
                        val  = a + imm;
                    end
                    OP_LW:
                    begin
                        wr   = 1'b1;
                        dest = rt;
                        val  = read_word(a + imm);
                    end
                    OP_SW:
                    begin
                        ea = a + imm;
                        if ({2'b00, ea[31:2]} < 32'(MEM_WORDS_DEF)) begin
                            word_mem[ea[11:2]] = b;
                            r.mem_written = 1'b1;
                        end
                    end
                    OP_BEQ: if (a == b) nxt = nxt + (imm << 2);
                    OP_BNE: if (a != b) nxt = nxt + (imm << 2);
                    OP_J:   nxt = {nxt[31:28], ins[25:0], 2'b00};
                    default: r.bad_instruction = 1'b1;
                endcase
                if (wr && dest != '0) begin
                    gpr[dest]     = val;
                    r.reg_written = 1'b1;
                    r.reg_index   = dest;
                    r.reg_value   = val;
                end
                pc_q = nxt;
            end
        end
        r.pc_after = pc_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (gpr[k])
                gpr[k] = '0;
            foreach (word_mem[k])
                word_mem[k] = '0;
            pc_q = '0;
            expected_rsp_q.delete();
            waiting = 0;
        end
        else begin
            // responses first: one accepted on this edge belongs to an earlier request
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("response transaction with nothing outstanding");
                    mismatches++;
                end
                else begin
                    want = expected_rsp_q.pop_front();
                    check_field("pc_after",        want.pc_after,        rsp.pc_after);
                    check_field("instruction",     want.instruction,     rsp.instruction);
                    check_field("reg_written",     32'(want.reg_written),
                                32'(rsp.reg_written));
                    check_field("reg_index",       32'(want.reg_index),
                                32'(rsp.reg_index));
                    check_field("reg_value",       want.reg_value,       rsp.reg_value);
                    check_field("mem_written",     32'(want.mem_written),
                                32'(rsp.mem_written));
                    check_field("halted",          32'(want.halted),
                                32'(rsp.halted));
                    check_field("bad_instruction", 32'(want.bad_instruction),
                                32'(rsp.bad_instruction));
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(run_core_item(req));
            waiting = expected_rsp_q.size();
        end
    end

endmodule

// ===== tb/tb_mips_subset_core_step_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mips_subset_core_step_unit
// Drives program loads and instruction steps into the step core, with random
// gaps and response back-pressure; the checker beside the core predicts and
// compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_mips_subset_core_step_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import msc_pkg::*;

    // rough item budget; the last stretch of it runs with no idling at all
    localparam int unsigned ITEM_TARGET  = 1950;
    localparam int unsigned QUIET_TAIL   = 150;
    // receiver hold-off long enough to fill the request buffer and output register
    localparam int unsigned LONG_HOLD    = 200;
    localparam int unsigned HOLD_AT_ITEM = 300;
    // drain time after the last response, to catch stray extras
    localparam int unsigned DRAIN_CYCLES = 20;
    // Worst correct run: ~2000 items, each with the longest gap, core step and receiver
    // stall, plus the memory sweep and the long hold: ~360 us.
    // Allow roughly eight times that.
    localparam int unsigned LIMIT_NS     = 3_000_000;

    // codes the core does not implement, for the bad-instruction cases
    localparam logic [5:0] FN_UNUSED = 6'h3F;
    localparam logic [5:0] OP_UNUSED = 6'h3F;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    int unsigned fail_count;
    int unsigned pending;

    bit          quiet      = 1'b0;  // end of run: no gaps, no stalls
    bit          hold_req   = 1'b0;  // asks the receiver for the long hold-off
    bit          hold_used  = 1'b0;
    int unsigned items_sent = 0;
    logic [31:0] boot_prog [15];

    mips_subset_core_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    msc_step_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---- instruction encoders ----------------------------------------------
    function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [4:0] sh, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(logic [25:0] idx);
        return {OP_J, idx};
    endfunction

    function automatic req_t load_req(logic [9:0] addr, logic [31:0] word);
        req_t r;
        r.req_type  = REQ_LOAD;
        r.load_addr = addr;
        r.load_word = word;
        return r;
    endfunction

    function automatic req_t step_req();
        req_t r;
        r           = '0;
        r.req_type  = REQ_STEP;
        return r;
    endfunction

    // mostly a small working set of registers, so results feed later operands
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 7));
    endfunction

    // one random program word; jumps and branches mostly stay near the program
    function automatic logic [31:0] random_instruction(int unsigned prog_len);
        logic [5:0]  fn_set [7] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT, FN_SLL, FN_SRL};
        logic [5:0]  code;
        logic [15:0] offs;
        int unsigned sel;
        sel = $urandom_range(0, 31);
        if (sel < 12)
            return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom_range(0, 31)),
                         fn_set[$urandom_range(0, 6)]);
        if (sel < 15) begin
            offs = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 32) - 16);
            return enc_i(OP_ADDI, pick_reg(), pick_reg(), offs);
        end
        if (sel < 21) begin
            code = (sel < 18) ? OP_LW : OP_SW;
            // zero base with an in-range word address, or anything at all
            if ($urandom_range(0, 3) != 0)
                return enc_i(code, 5'd0, pick_reg(),
                             16'(($urandom_range(0, 1023) << 2) | $urandom_range(0, 3)));
            return enc_i(code, pick_reg(), pick_reg(), 16'($urandom));
        end
        if (sel < 25) begin
            code = (sel < 23) ? OP_BEQ : OP_BNE;
            offs = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 8) - 4);
            return enc_i(code, pick_reg(), pick_reg(), offs);
        end
        if (sel < 27)
            return ($urandom_range(0, 3) == 0) ? enc_j(26'($urandom))
                                               : enc_j(26'($urandom_range(0, prog_len + 2)));
        if (sel < 29) begin
            if ($urandom_range(0, 1) == 0) begin
                do
                    code = 6'($urandom);
                while (code inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT, FN_SLL, FN_SRL});
                return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), code);
            end
            do
                code = 6'($urandom);
            while (code inside {OP_RTYPE, OP_J, OP_BEQ, OP_BNE, OP_ADDI, OP_LW, OP_SW});
            return {code, 26'($urandom)};
        end
        if (sel == 29)
            return '0;
        return $urandom;
    endfunction

    // Offer one request transaction. Entered and left at a falling edge; valid
    // only drops for a random gap, never on the back of the stall signal.
    task automatic offer_item(input req_t item);
        if (!quiet && !hold_req && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // ---- receiver back-pressure ---------------------------------------------
    // Random stall bursts, free-running stretches, and one long hold-off on
    // request so the core backs up into its request channel.
    initial begin
        rsp_stall = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                rsp_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0) begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            @(negedge clk);
        end
    end

    // ---- stimulus and verdict -----------------------------------------------
    initial begin
        int unsigned plen;
        int unsigned nsteps;
        req_t        item;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed program: every operation but beq, wrap-around, a write to r0, stores
        // and loads at the top word, a store beyond memory is left to the random
        // part. The bne skips word 11; the last jump lands past the end of
        // memory, so the final step fetches zero and reports halted.
        boot_prog = '{
            enc_i(OP_ADDI, 5'd0, 5'd1, 16'hFFFF),     // r1 = all ones
            enc_r(5'd0, 5'd1, 5'd2, 5'd1, FN_SRL),    // logical shift: 7fffffff
            enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD),    // wraps
            enc_r(5'd1, 5'd2, 5'd4, 5'd0, FN_SUB),    // 80000000
            enc_r(5'd4, 5'd2, 5'd5, 5'd0, FN_SLT),    // signed compare: 1
            enc_r(5'd0, 5'd1, 5'd0, 5'd31, FN_SLL),   // r0 target, no write
            enc_r(5'd4, 5'd1, 5'd6, 5'd0, FN_AND),
            enc_r(5'd5, 5'd4, 5'd7, 5'd0, FN_OR),
            enc_i(OP_SW, 5'd0, 5'd1, 16'h0FFC),       // top word of memory
            enc_i(OP_LW, 5'd0, 5'd8, 16'h0FFC),
            enc_i(OP_BNE, 5'd5, 5'd0, 16'd1),         // taken
            32'd0,
            enc_r(5'd1, 5'd2, 5'd9, 5'd0, FN_UNUSED),
            enc_i(OP_UNUSED, 5'd1, 5'd9, 16'h1234),
            enc_j(26'h3FFFFFF)
        };
        foreach (boot_prog[i])
            if (boot_prog[i] != '0)
                offer_item(load_req(10'(i), boot_prog[i]));
        repeat (15) offer_item(step_req());

        // Random part: mostly whole programs (a little data, the code from word
        // 0, then a run of steps); one in ten rounds is raw noise.
        while (items_sent < ITEM_TARGET) begin
            quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
            if (!hold_used && items_sent >= HOLD_AT_ITEM) begin
                hold_req  = 1'b1;
                hold_used = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    item.req_type  = 1'($urandom);
                    item.load_addr = 10'($urandom);
                    item.load_word = $urandom;
                    offer_item(item);
                end
            end
            else begin
                plen   = $urandom_range(4, 24);
                nsteps = $urandom_range(plen, 2 * plen + 4);
                repeat ($urandom_range(0, 3))
                    offer_item(load_req(10'($urandom), $urandom));
                for (int unsigned w = 0; w < plen; w++)
                    offer_item(load_req(10'(w), random_instruction(plen)));
                repeat (nsteps) offer_item(step_req());
            end
        end
        req_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS mips_subset_core_step_unit");
        else
            $display("FAIL mips_subset_core_step_unit");
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("FAIL mips_subset_core_step_unit");
        $finish;
    end

endmodule
